@@ design/lcfc_pkg.sv @@
// lcfc_pkg: shared types, constants and tables for the feedback cipher
// depends on: nothing
`default_nettype none

package lcfc_pkg;

  localparam int unsigned NumShift = 16;
  localparam int unsigned NumMix   = 8;
  localparam int unsigned NumQueue = 4;

  localparam logic [1:0] CfgKeyLow  = 2'd0;
  localparam logic [1:0] CfgKeyHigh = 2'd1;
  localparam logic [1:0] CfgDecrypt = 2'd2;

  localparam logic CmdStart = 1'b0;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StPrep  = 5'b00100,
    StMix   = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  typedef logic [7:0] byte_t;

  localparam byte_t TapMask [NumShift] = '{
    8'h0B, 8'h0A, 8'h78, 8'h0C, 8'hE0, 8'h29, 8'h7B, 8'hCF,
    8'hC3, 8'h4B, 8'h2B, 8'hCC, 8'h82, 8'h60, 8'h80, 8'h06
  };

  localparam byte_t SelBits [64] = '{
    8'h96, 8'h4b, 8'h65, 8'h3a, 8'hac, 8'h6c, 8'h53, 8'h74,
    8'h78, 8'ha5, 8'h47, 8'hb2, 8'h4d, 8'ha6, 8'h59, 8'h5a,
    8'h8d, 8'h56, 8'h2b, 8'hc3, 8'h71, 8'hd2, 8'h66, 8'h3c,
    8'h1d, 8'hc9, 8'h93, 8'h2e, 8'ha9, 8'h72, 8'h17, 8'hb1,
    8'hb4, 8'he4, 8'ha3, 8'h4e, 8'h27, 8'h5c, 8'h8b, 8'hc5,
    8'he8, 8'h95, 8'he1, 8'hd1, 8'h87, 8'hb8, 8'h1e, 8'hca,
    8'h1b, 8'h63, 8'hd8, 8'h2d, 8'hd4, 8'h9a, 8'h99, 8'h36,
    8'h8e, 8'hc6, 8'h69, 8'he2, 8'h39, 8'h35, 8'h6a, 8'h9c
  };

  localparam logic [3:0] NibSub [NumQueue][16] = '{
    '{4'h6, 4'hA, 4'h1, 4'h2, 4'hE, 4'h7, 4'h8, 4'h9,
      4'hC, 4'h4, 4'h3, 4'hF, 4'hB, 4'h0, 4'h5, 4'hD},
    '{4'h2, 4'h7, 4'h0, 4'h5, 4'hF, 4'h3, 4'h1, 4'h9,
      4'hE, 4'hD, 4'hB, 4'h8, 4'hC, 4'hA, 4'h4, 4'h6},
    '{4'h9, 4'h1, 4'h3, 4'hC, 4'h2, 4'h0, 4'hA, 4'hE,
      4'hD, 4'h6, 4'hB, 4'h7, 4'h5, 4'h8, 4'hF, 4'h4},
    '{4'hB, 4'h6, 4'h9, 4'h0, 4'h5, 4'hE, 4'hF, 4'h8,
      4'h4, 4'hC, 4'h1, 4'hD, 4'h2, 4'h7, 4'h3, 4'hA}
  };

  // high nibble becomes inverted low nibble or'ed with high nibble
  function automatic byte_t spread_nibble(input byte_t v);
    return {~v[3:0] | v[7:4], v[3:0]};
  endfunction

  function automatic byte_t rotl8(input byte_t v, input logic [2:0] r);
    logic [15:0] w;
    w = {v, v} << r;
    return w[15:8];
  endfunction

endpackage

`default_nettype wire

@@ design/lfsr_ciphertext_feedback_cipher.sv @@
// lfsr_ciphertext_feedback_cipher: byte stream cipher with ciphertext feedback
// depends on: lcfc_pkg
// start transaction: state loaded in the accept cycle, no result, ready again next cycle
// data transaction: result valid after 32 register rounds on one shared round unit,
//   one prep step, 8 table bit steps and one finish step that waits for a free output
// no new data byte until the last one is finished; input accepted only while idle
// reset: key, mode, cipher state and byte count all zero, output empty
`default_nettype none

module lfsr_ciphertext_feedback_cipher
  import lcfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       result_byte_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  state_e      state_q, state_d;
  logic [63:0] key_low_q, key_low_d, key_high_q, key_high_d;
  logic        decrypt_q, decrypt_d;
  byte_t       shift_q [NumShift];
  byte_t       shift_d [NumShift];
  byte_t       mix_q [NumMix];
  byte_t       mix_d [NumMix];
  byte_t       fq_q [NumQueue];
  byte_t       fq_d [NumQueue];
  logic [2:0]  cnt_q, cnt_d;
  logic [4:0]  rc_q, rc_d;
  logic [2:0]  step_q, step_d;
  byte_t       lo_q [NumQueue];
  byte_t       lo_d [NumQueue];
  byte_t       pb_q [NumQueue];
  byte_t       pb_d [NumQueue];
  byte_t       acc_q, acc_d;
  byte_t       data_q, data_d;
  byte_t       res_q, res_d;
  logic        out_valid_q, out_valid_d;

  byte_t       round_acc;
  byte_t       round_mix;
  logic [3:0]  slot;
  logic [5:0]  sel;
  byte_t       ks;
  byte_t       res;
  byte_t       fb;

  // shared round unit: tap-masked parity over all register bytes
  always_comb begin
    round_acc = '0;
    for (int i = 0; i < NumShift; i++) begin
      round_acc ^= shift_q[i] & TapMask[rc_q[3:0] + 4'(i)];
    end
    round_mix = ((round_acc >> 1) ^ round_acc) & 8'h55;
    slot = ~rc_q[3:0];
  end

  assign sel = {lo_q[1][7], pb_q[1][7], lo_q[2][7], pb_q[2][7], lo_q[3][7], pb_q[3][7]};
  assign ks  = rotl8(acc_q ^ pb_q[0] ^ lo_q[0], cnt_q);
  assign res = data_q ^ ks;
  assign fb  = decrypt_q ? data_q : res;

  always_comb begin
    state_d     = state_q;
    key_low_d   = key_low_q;
    key_high_d  = key_high_q;
    decrypt_d   = decrypt_q;
    shift_d     = shift_q;
    mix_d       = mix_q;
    fq_d        = fq_q;
    cnt_d       = cnt_q;
    rc_d        = rc_q;
    step_d      = step_q;
    lo_d        = lo_q;
    pb_d        = pb_q;
    acc_d       = acc_q;
    data_d      = data_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyLow:  key_low_d  = cfg_wdata_i;
        CfgKeyHigh: key_high_d = cfg_wdata_i;
        CfgDecrypt: decrypt_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (cmd_i == CmdStart) begin
            for (int i = 0; i < NumQueue; i++) begin
              mix_d[i] = spread_nibble(key_low_q[8*i +: 8] ^ key_low_q[8*(i+4) +: 8]);
              mix_d[i+4] = spread_nibble(key_high_q[8*i +: 8] ^ key_high_q[8*(i+4) +: 8]);
              fq_d[i] = mix_d[i] ^ mix_d[i+4] ^ 8'hF0;
            end
            for (int i = 0; i < 8; i++) begin
              shift_d[i] = spread_nibble(key_low_q[8*i +: 8]);
            end
            for (int i = 0; i < 7; i++) begin
              shift_d[i+8] = spread_nibble(key_high_q[8*i +: 8]);
            end
            shift_d[NumShift-1] = 8'hFF;
            cnt_d = '0;
          end else begin
            data_d  = data_byte_i;
            rc_d    = '1;
            state_d = StRound;
          end
        end
      end
      StRound: begin
        shift_d[slot] = ((shift_q[slot] << 1) & 8'hAA) | round_mix;
        rc_d = rc_q - 5'd1;
        if (rc_q == '0) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        for (int i = 0; i < NumQueue; i++) begin
          byte_t t;
          t = mix_q[i] ^ fq_q[i];
          lo_d[i] = rotl8(shift_q[i+7], 3'd2) ^ shift_q[i];
          pb_d[i] = {NibSub[i][t[7:4]], NibSub[i][t[3:0]]} ^ mix_q[i+4];
        end
        acc_d   = '0;
        step_d  = '0;
        state_d = StMix;
      end
      StMix: begin
        acc_d = {acc_q[6:0], SelBits[sel][3'd7 - step_q]};
        for (int i = 1; i < NumQueue; i++) begin
          lo_d[i] = lo_q[i] << 1;
          pb_d[i] = pb_q[i] << 1;
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          res_d       = res;
          out_valid_d = 1'b1;
          for (int i = 0; i < NumQueue - 1; i++) begin
            fq_d[i] = rotl8(fq_q[i+1], 3'd1);
          end
          fq_d[NumQueue-1] = rotl8(fb, 3'd1);
          cnt_d   = cnt_q + 3'd1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      key_low_q   <= '0;
      key_high_q  <= '0;
      decrypt_q   <= 1'b0;
      cnt_q       <= '0;
      rc_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumShift; i++) begin
        shift_q[i] <= '0;
      end
      for (int i = 0; i < NumMix; i++) begin
        mix_q[i] <= '0;
      end
      for (int i = 0; i < NumQueue; i++) begin
        fq_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      key_low_q   <= key_low_d;
      key_high_q  <= key_high_d;
      decrypt_q   <= decrypt_d;
      cnt_q       <= cnt_d;
      rc_q        <= rc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      shift_q     <= shift_d;
      mix_q       <= mix_d;
      fq_q        <= fq_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    pb_q   <= pb_d;
    acc_q  <= acc_d;
    data_q <= data_d;
    res_q  <= res_d;
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign result_byte_o = res_q;

endmodule

`default_nettype wire
